/* design/brf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Request and result layouts, opcode set, controller states and the
// command bundle that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

    // field widths fixed by the request and result formats
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int AMT_W  = 11;
    localparam int LVL_W  = 11;
    localparam int POS_W  = 10;

    // opcodes; codes five to seven are no-ops
    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_ADV_RD  = 3'd2,
        OP_ADV_WR  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    // one request
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic [AMT_W-1:0]  amount;
        logic              burst_last;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic [AMT_W-1:0]  moved;
        logic [LVL_W-1:0]  fill_level;
        logic [POS_W-1:0]  head_offset;
        logic [POS_W-1:0]  tail_offset;
        logic [LVL_W-1:0]  readable_span;
        logic [LVL_W-1:0]  writable_span;
        logic              last;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic exec;
    } t_ctrl_cmd;

endpackage : brf_pkg
`default_nettype wire

/* design/byte_ring_fifo_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit: byte circular FIFO with pointer advance and status
// Write, read, advance-read, advance-write and clear requests; every
// request returns one result with fill level, pointers and spans.
//
//   channel  dir  handshake                   payload
//   in       in   i_in_valid / o_in_ready     i_in_item  (brf_pkg::t_in_item)
//   out      out  o_out_valid / i_out_ready   o_out_item (brf_pkg::t_out_item)
//
// A request passes through an execute state and then shows its result.
// Read data of the single-port byte store is registered. A request is
// accepted while a result waits; it executes once that result is taken.
// Synchronous active-low reset empties the FIFO; store contents are not
// cleared.
// ----------------------------------------------------------------------------
module byte_ring_fifo_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire brf_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output brf_pkg::t_out_item      o_out_item
);
    import brf_pkg::*;

    t_ctrl_cmd cmd;

    // sequencing
    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // store, pointers and status
    brf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_item),
        .o_res   (o_out_item)
    );

endmodule : byte_ring_fifo_unit
`default_nettype wire

/* design/brf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ctrl: sequencing controller of the byte ring FIFO
// Holds the request-pending flag and walks each request through an
// execute state and a result state.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output brf_pkg::t_ctrl_cmd      o_cmd
);
    import brf_pkg::*;

    t_state r_state, n_state;
    logic   r_pend,  n_pend;
    logic   in_fire;

    // request register is free unless a request waits for execution
    assign o_in_ready  = !r_pend;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_OUT);

    // state and pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.load_req = in_fire;
        o_cmd.exec     = 1'b0;
        if (in_fire) begin
            n_pend = 1'b1;
        end else begin
            n_pend = r_pend;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_pend     = 1'b0;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_pend || in_fire) begin
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : brf_ctrl
`default_nettype wire

/* design/brf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_dp: datapath of the byte ring FIFO
// Request register, byte store, head/tail pointers, fill count, result
// registers and the span calculation for the reported status.
// ----------------------------------------------------------------------------
module brf_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire brf_pkg::t_ctrl_cmd  i_cmd,
    input  wire brf_pkg::t_in_item   i_req,
    output brf_pkg::t_out_item       o_res
);
    import brf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > AMT_W) ? CNT_W : AMT_W;
    localparam int LW_W  = (CNT_W > LVL_W) ? CNT_W : LVL_W;
    localparam int PW_W  = (PTR_W > POS_W) ? PTR_W : POS_W;

    // pointer step with wrap at capacity; step never exceeds DEPTH
    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] pos,
                                                 input logic [CNT_W-1:0] step);
        logic [SUM_W-1:0] s;
        s = SUM_W'(pos) + SUM_W'(step);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    t_in_item          r_req;
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_moved, n_moved;
    logic              r_done, n_done;
    logic              r_rd_ok;
    logic              r_last;
    logic              mem_we, mem_re;
    logic              full, empty;
    logic [CNT_W-1:0]  room;
    logic [CMP_W-1:0]  amt_c, cnt_c, room_c, adv_rd_c, adv_wr_c;
    logic [CNT_W-1:0]  adv_rd, adv_wr;
    logic [CNT_W-1:0]  rd_span, wr_span;
    logic [LW_W-1:0]   fill_w, moved_w, rd_span_w, wr_span_w;
    logic [PW_W-1:0]   head_w, tail_w;

    // request register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
    end

    // occupancy and clamped advance amounts
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign room     = CNT_W'(DEPTH) - r_count;
    assign amt_c    = CMP_W'(r_req.amount);
    assign cnt_c    = CMP_W'(r_count);
    assign room_c   = CMP_W'(room);
    assign adv_rd_c = (amt_c < cnt_c)  ? amt_c : cnt_c;
    assign adv_wr_c = (amt_c < room_c) ? amt_c : room_c;
    assign adv_rd   = adv_rd_c[CNT_W-1:0];
    assign adv_wr   = adv_wr_c[CNT_W-1:0];

    // opcode decode and next pointer state
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_moved = '0;
        n_done  = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        unique case (r_req.op)
            OP_WRITE: begin
                if (!full) begin
                    mem_we  = 1'b1;
                    n_tail  = f_wrap(r_tail, CNT_W'(1));
                    n_count = r_count + CNT_W'(1);
                    n_done  = 1'b1;
                end
            end
            OP_READ: begin
                if (!empty) begin
                    mem_re  = 1'b1;
                    n_head  = f_wrap(r_head, CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_done  = 1'b1;
                end
            end
            OP_ADV_RD: begin
                n_moved = adv_rd;
                n_head  = f_wrap(r_head, adv_rd);
                n_count = r_count - adv_rd;
            end
            OP_ADV_WR: begin
                n_moved = adv_wr;
                n_tail  = f_wrap(r_tail, adv_wr);
                n_count = r_count + adv_wr;
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // per-request result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_moved <= n_moved;
            r_done  <= n_done;
            r_rd_ok <= mem_re;
            r_last  <= r_req.burst_last;
        end
    end

    // byte store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_tail] <= r_req.data_byte;
        end
        if (i_cmd.exec && mem_re) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // contiguous spans from the settled pointers
    always_comb begin
        if (empty) begin
            rd_span = '0;
        end else if (r_head < r_tail) begin
            rd_span = CNT_W'(r_tail) - CNT_W'(r_head);
        end else begin
            rd_span = CNT_W'(DEPTH) - CNT_W'(r_head);
        end
        if (full) begin
            wr_span = '0;
        end else if (r_tail >= r_head) begin
            wr_span = CNT_W'(DEPTH) - CNT_W'(r_tail);
        end else begin
            wr_span = CNT_W'(r_head) - CNT_W'(r_tail);
        end
    end

    // fit internal widths to the result fields
    assign fill_w    = LW_W'(r_count);
    assign moved_w   = LW_W'(r_moved);
    assign rd_span_w = LW_W'(rd_span);
    assign wr_span_w = LW_W'(wr_span);
    assign head_w    = PW_W'(r_head);
    assign tail_w    = PW_W'(r_tail);

    assign o_res.read_byte     = r_rd_ok ? r_rdata : '0;
    assign o_res.done_res      = r_done;
    assign o_res.moved         = moved_w[AMT_W-1:0];
    assign o_res.fill_level    = fill_w[LVL_W-1:0];
    assign o_res.head_offset   = head_w[POS_W-1:0];
    assign o_res.tail_offset   = tail_w[POS_W-1:0];
    assign o_res.readable_span = rd_span_w[LVL_W-1:0];
    assign o_res.writable_span = wr_span_w[LVL_W-1:0];
    assign o_res.last          = r_last;

endmodule : brf_dp
`default_nettype wire

/* dv/byte_ring_fifo_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit_tb: self-checking bench for the byte ring FIFO
// Drives write, read, advance and clear requests with random gaps on the
// request side and random stalls on the result side. A scoreboard tracks
// store contents, pointers and fill level and compares every status word.
// ----------------------------------------------------------------------------
module byte_ring_fifo_unit_tb;
    import brf_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int N_RANDOM     = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 40;

    // mirror of the FIFO: store, pointers, fill level and the status due next
    class fifo_scoreboard;
        bit [BYTE_W-1:0] store [DEPTH];
        bit              written [DEPTH];
        int              head, tail, fill;
        t_out_item       status_due [$];
        int errors, checked;
        int full_drops, empty_reads, clamps, wraps;

        function int step(int pos, int n);
            if (pos + n >= DEPTH)
                wraps++;
            return (pos + n) % DEPTH;
        endfunction

        // apply one accepted request and queue the status it must produce
        function void note_request(t_in_item req);
            t_out_item want;
            int        mv;
            want = '0;
            want.last = req.burst_last;
            case (req.op)
                OP_WRITE: begin
                    if (fill < DEPTH) begin
                        store[tail]   = req.data_byte;
                        written[tail] = 1'b1;
                        tail = step(tail, 1);
                        fill++;
                        want.done_res = 1'b1;
                    end else begin
                        full_drops++;
                    end
                end
                OP_READ: begin
                    if (fill > 0) begin
                        want.read_byte = store[head];
                        head = step(head, 1);
                        fill--;
                        want.done_res = 1'b1;
                    end else begin
                        empty_reads++;
                    end
                end
                OP_ADV_RD: begin
                    mv = (req.amount < fill) ? req.amount : fill;
                    if (mv < req.amount)
                        clamps++;
                    head = step(head, mv);
                    fill -= mv;
                    want.moved = AMT_W'(mv);
                end
                OP_ADV_WR: begin
                    mv = (req.amount < DEPTH - fill) ? req.amount : DEPTH - fill;
                    if (mv < req.amount)
                        clamps++;
                    tail = step(tail, mv);
                    fill += mv;
                    want.moved = AMT_W'(mv);
                end
                OP_CLEAR: begin
                    head = 0;
                    tail = 0;
                    fill = 0;
                end
                default: ;
            endcase
            want.fill_level  = LVL_W'(fill);
            want.head_offset = POS_W'(head);
            want.tail_offset = POS_W'(tail);
            if (fill == 0)
                want.readable_span = '0;
            else if (head < tail)
                want.readable_span = LVL_W'(tail - head);
            else
                want.readable_span = LVL_W'(DEPTH - head);
            if (fill >= DEPTH)
                want.writable_span = '0;
            else if (tail >= head)
                want.writable_span = LVL_W'(DEPTH - tail);
            else
                want.writable_span = LVL_W'(head - tail);
            status_due.push_back(want);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t MISMATCH %s: got %0d, expected %0d (status %0d)",
                         $realtime, what, got, want, checked);
        endtask

        task check_status(t_out_item got);
            t_out_item want;
            if (status_due.size() == 0) begin
                report_mismatch("status with no request outstanding", 0, 0);
                return;
            end
            want = status_due.pop_front();
            checked++;
            if (got.read_byte !== want.read_byte)
                report_mismatch("read_byte", int'(got.read_byte), int'(want.read_byte));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            if (got.moved !== want.moved)
                report_mismatch("moved", int'(got.moved), int'(want.moved));
            if (got.fill_level !== want.fill_level)
                report_mismatch("fill_level", int'(got.fill_level), int'(want.fill_level));
            if (got.head_offset !== want.head_offset)
                report_mismatch("head_offset", int'(got.head_offset),
                                int'(want.head_offset));
            if (got.tail_offset !== want.tail_offset)
                report_mismatch("tail_offset", int'(got.tail_offset),
                                int'(want.tail_offset));
            if (got.readable_span !== want.readable_span)
                report_mismatch("readable_span", int'(got.readable_span),
                                int'(want.readable_span));
            if (got.writable_span !== want.writable_span)
                report_mismatch("writable_span", int'(got.writable_span),
                                int'(want.writable_span));
            if (got.last !== want.last)
                report_mismatch("last", int'(got.last), int'(want.last));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_ready = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    fifo_scoreboard sb = new();
    bit             calm;
    int             requests_sent;
    int             directed_sent;
    int             cycles;

    byte_ring_fifo_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // present one request from a falling edge and hold it until taken
    task automatic drive_request(input t_in_item req);
        int gap;
        // a pop must never land on a slot skipped by an advance write
        if (req.op == OP_READ && sb.fill > 0 && !sb.written[sb.head]) begin
            req.op     = OP_ADV_RD;
            req.amount = AMT_W'(1);
        end
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_op(input int op, input int d, input int amt, input int last);
        t_in_item req;
        req.op         = OP_W'(op);
        req.data_byte  = BYTE_W'(d);
        req.amount     = AMT_W'(amt);
        req.burst_last = last[0];
        drive_request(req);
    endtask

    // result side: random stall before each status is taken
    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_status(o_out_item);
            @(negedge i_clk);
        end
    end

    // request side: directed corners, then random bulk calls
    initial begin
        int                len, pick, lim;
        logic [OP_W-1:0]   adv_op;
        int                amt;
        t_in_item          noise;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty FIFO: pop and advance both give nothing
        send_op(OP_READ, 8'h3C, 11'd7, 1'b1);
        send_op(OP_ADV_RD, 8'h00, 11'd5, 1'b0);
        // byte extremes through a short bulk write and read
        send_op(OP_WRITE, 8'h00, 11'd0, 1'b0);
        send_op(OP_WRITE, 8'hFF, 11'd1024, 1'b0);
        send_op(OP_WRITE, 8'hA5, 11'd0, 1'b1);
        send_op(OP_READ, 8'h00, 11'd0, 1'b0);
        send_op(OP_READ, 8'hFF, 11'd2, 1'b0);
        send_op(OP_READ, 8'h11, 11'd0, 1'b1);
        send_op(OP_READ, 8'h22, 11'd0, 1'b0);
        // fill to capacity by advance, then a dropped write and a null advance
        send_op(OP_ADV_WR, 8'h00, 11'd1024, 1'b0);
        send_op(OP_WRITE, 8'h81, 11'd0, 1'b1);
        send_op(OP_ADV_WR, 8'h00, 11'd1, 1'b0);
        send_op(OP_ADV_RD, 8'h00, 11'd1024, 1'b1);
        // pointer wrap at the end of the store
        send_op(OP_CLEAR, 8'h77, 11'd300, 1'b0);
        send_op(OP_ADV_WR, 8'h00, 11'd1023, 1'b0);
        send_op(OP_WRITE, 8'h5A, 11'd0, 1'b1);
        send_op(OP_ADV_RD, 8'h00, 11'd1023, 1'b0);
        send_op(OP_READ, 8'h00, 11'd0, 1'b1);
        // unused opcodes only report status
        for (int c = int'(OP_CLEAR) + 1; c < (1 << OP_W); c++)
            send_op(c, $urandom, $urandom_range(0, DEPTH), $urandom_range(0, 1));
        send_op(OP_ADV_RD, 8'h00, 11'd0, 1'b0);
        send_op(OP_ADV_WR, 8'h00, 11'd0, 1'b1);
        send_op(OP_CLEAR, 8'h00, 11'd0, 1'b0);
        directed_sent = requests_sent;

        while (requests_sent - directed_sent < N_RANDOM) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300)
                                                : $urandom_range(1, 40);
            if (pick < 35) begin
                // bulk write call
                for (int k = 0; k < len; k++)
                    send_op(OP_WRITE, $urandom, $urandom_range(0, DEPTH), k == len - 1);
            end else if (pick < 65) begin
                // bulk read call, often running past the stored bytes
                for (int k = 0; k < len; k++)
                    send_op(OP_READ, $urandom, $urandom_range(0, DEPTH), k == len - 1);
            end else if (pick < 88) begin
                // zero-copy commit of a read or write region
                adv_op = ($urandom_range(0, 9) < 6) ? OP_ADV_RD : OP_ADV_WR;
                lim = (adv_op == OP_ADV_RD) ? sb.fill : DEPTH - sb.fill;
                case ($urandom_range(0, 5))
                    0:       amt = 0;
                    1:       amt = DEPTH;
                    2:       amt = lim;
                    3:       amt = (lim < DEPTH) ? lim + 1 : DEPTH;
                    4:       amt = $urandom_range(0, DEPTH);
                    default: amt = $urandom_range(1, 16);
                endcase
                send_op(adv_op, $urandom, amt, $urandom_range(0, 1));
            end else if (pick < 91) begin
                send_op(OP_CLEAR, $urandom, $urandom_range(0, DEPTH), $urandom_range(0, 1));
            end else if (pick < 95) begin
                send_op($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1), $urandom,
                        $urandom_range(0, DEPTH), $urandom_range(0, 1));
            end else begin
                // short run of requests with every field random
                for (int k = 0; k < (len % 8) + 1; k++) begin
                    noise.op         = OP_W'($urandom_range(0, (1 << OP_W) - 1));
                    noise.data_byte  = BYTE_W'($urandom);
                    noise.amount     = AMT_W'($urandom_range(0, DEPTH));
                    noise.burst_last = 1'($urandom_range(0, 1));
                    drive_request(noise);
                end
            end
        end
        i_in_valid <= 1'b0;

        // let every status come back, then give the block time to misbehave
        while (sb.status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d directed), %0d status words checked, %0d cycles",
                 requests_sent, directed_sent, sb.checked, cycles);
        $display("full drops %0d, empty reads %0d, clamped advances %0d, pointer wraps %0d",
                 sb.full_drops, sb.empty_reads, sb.clamps, sb.wraps);
        if (sb.errors == 0 && sb.status_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
design/brf_pkg.sv
design/brf_ctrl.sv
design/brf_dp.sv
design/byte_ring_fifo_unit.sv
dv/byte_ring_fifo_unit_tb.sv
